### rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants and codes for the next-fit page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int MAX_PAGES_DEF = 65536;
  localparam int PAGE_SHIFT    = 12;
  localparam int ADDR_W        = 64;
  localparam int COUNT_W       = 17;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_INIT  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOT_USED = 2'd3
  } status_t;

  localparam logic CFG_REGION_BASE = 1'b0;
  localparam logic CFG_PAGE_COUNT  = 1'b1;

endpackage

### rtl/page_frame_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_allocator
// Next-fit allocator of 4 KiB page frames over a configured region.
// ----------------------------------------------------------------------------
// One used flag per page lives in a single-port-write, single-port-read
// memory of MAX_PAGES bits with a registered read. After reset the block runs
// a clearing pass over the whole map before it takes the first item. An
// allocate item streams one map read per cycle from the cursor and visits at
// most the page count of pages; on a full map it visits every page. A free
// item runs a range check, a map read and a write back; the last two are
// skipped when the address is outside the region. An init item rewrites the
// whole map, one entry per cycle. One item is in work at a time; the result
// register lets the next item be taken while a result waits on the output.
// ----------------------------------------------------------------------------
module page_frame_allocator #(
  parameter int MAX_PAGES = pfa_pkg::MAX_PAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [pfa_pkg::ADDR_W-1:0]   cfg_data,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   req_type,
  input  logic [pfa_pkg::ADDR_W-1:0]   page_address,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [pfa_pkg::ADDR_W-1:0]   granted_address
);

  import pfa_pkg::*;

  localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW = $clog2(MAX_PAGES + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FCHK,
    S_FRD,
    S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [ADDR_W-1:0]  region_base;
  logic [COUNT_W-1:0] page_count;

  // allocator state and work registers
  logic [IW-1:0]      cursor;
  logic [IW-1:0]      clr_idx;
  logic               init_mode;
  logic [IW-1:0]      rd_idx;
  logic [IW-1:0]      chk_idx;
  logic               chk_valid;
  logic [CW-1:0]      issued;
  logic               below;
  logic [ADDR_W-1:0]  diff;
  logic [1:0]         res_status;
  logic [ADDR_W-1:0]  res_addr;

  // map memory
  logic               page_used [MAX_PAGES];
  logic               mem_we;
  logic [IW-1:0]      mem_wa;
  logic               mem_wd;
  logic               mem_re;
  logic [IW-1:0]      mem_ra;
  logic               rd_data;

  // derived values
  logic [31:0]        live_wide;
  logic [CW-1:0]      live;
  logic [CW-1:0]      reserved;
  logic [CW-1:0]      rd_inc;
  logic               rd_wrap;
  logic               hit;
  logic               issue;
  logic               range_err;
  logic [IW-1:0]      free_idx;
  logic               res_free;

  always_comb begin
    live_wide = ({15'd0, page_count} > 32'(MAX_PAGES)) ? 32'(MAX_PAGES)
                                                       : {15'd0, page_count};
    live      = CW'(live_wide);
    reserved  = live >> PAGE_SHIFT;
    rd_inc    = CW'(rd_idx) + CW'(1);
    rd_wrap   = (rd_inc >= live);
    hit       = chk_valid && !rd_data;
    issue     = (state == S_SCAN) && !hit && (issued != live);
    range_err = below || ({{PAGE_SHIFT{1'b0}}, diff[ADDR_W-1:PAGE_SHIFT]}
                          >= ADDR_W'(live));
    free_idx  = diff[PAGE_SHIFT +: IW];
    res_free  = !out_valid || out_ready;
    in_ready  = (state == S_IDLE);
  end

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_idx;
    mem_wd = 1'b0;
    mem_re = 1'b0;
    mem_ra = rd_idx;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx;
        mem_wd = init_mode && (CW'(clr_idx) < reserved);
      end
      S_SCAN: begin
        if (hit) begin
          mem_we = 1'b1;
          mem_wa = chk_idx;
          mem_wd = 1'b1;
        end else if (issue) begin
          mem_re = 1'b1;
          mem_ra = rd_idx;
        end
      end
      S_FCHK: begin
        mem_re = !range_err;
        mem_ra = free_idx;
      end
      S_FRD: begin
        mem_we = rd_data;
        mem_wa = free_idx;
        mem_wd = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_used[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= page_used[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      page_count  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REGION_BASE: region_base <= cfg_data;
        CFG_PAGE_COUNT:  page_count  <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cursor    <= '0;
      clr_idx   <= '0;
      init_mode <= 1'b0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && res_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_idx == IW'(MAX_PAGES - 1)) begin
            init_mode <= 1'b0;
            if (init_mode) begin
              if (reserved != '0) begin
                cursor <= IW'(reserved - CW'(1));
              end
              res_status <= ST_OK;
              state      <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            clr_idx <= clr_idx + IW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            res_addr <= '0;
            case (req_type)
              REQ_ALLOC: begin
                if (live == '0) begin
                  res_status <= ST_OOM;
                  state      <= S_DONE;
                end else begin
                  rd_idx    <= (CW'(cursor) < live) ? cursor : '0;
                  issued    <= '0;
                  chk_valid <= 1'b0;
                  state     <= S_SCAN;
                end
              end
              REQ_FREE: begin
                below <= (page_address < region_base);
                diff  <= page_address - region_base;
                state <= S_FCHK;
              end
              REQ_INIT: begin
                init_mode <= 1'b1;
                clr_idx   <= '0;
                state     <= S_CLEAR;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          // reads stream one per cycle; data for chk_idx arrives in the cycle after its read
          if (hit) begin
            cursor     <= chk_idx;
            res_status <= ST_OK;
            res_addr   <= region_base + (ADDR_W'(chk_idx) << PAGE_SHIFT);
            state      <= S_DONE;
          end else if (issued == live) begin
            res_status <= ST_OOM;
            state      <= S_DONE;
          end else begin
            rd_idx    <= rd_wrap ? '0 : IW'(rd_inc);
            issued    <= issued + CW'(1);
            chk_idx   <= rd_idx;
            chk_valid <= 1'b1;
          end
        end
        S_FCHK: begin
          if (range_err) begin
            res_status <= ST_RANGE;
            state      <= S_DONE;
          end else begin
            state <= S_FRD;
          end
        end
        S_FRD: begin
          res_status <= rd_data ? ST_OK : ST_NOT_USED;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (res_free) begin
            status          <= res_status;
            granted_address <= res_addr;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the next-fit page frame allocator. A shadow copy of
// the page map and cursor predicts status and granted address for every
// accepted request; results are matched in order. Directed corner cases run
// first, then random alloc, free, init and unused-code traffic over several region settings.
// ----------------------------------------------------------------------------

class frame_map_tracker;
  typedef struct packed {
    pfa_pkg::status_t code;
    logic [63:0]      addr;
  } grant_t;

  logic [63:0] base;
  logic [16:0] count;
  bit          used_map [pfa_pkg::MAX_PAGES_DEF];
  int unsigned cursor;
  grant_t      grant_q[$];
  int unsigned fail_count;

  function new();
    base       = '0;
    count      = '0;
    cursor     = 0;
    fail_count = 0;
    foreach (used_map[i]) used_map[i] = 1'b0;
  endfunction

  function void set_region(logic [63:0] b, logic [63:0] c);
    base  = b;
    count = c[16:0];
  endfunction

  function int unsigned live_pages();
    return (count > pfa_pkg::MAX_PAGES_DEF) ? pfa_pkg::MAX_PAGES_DEF : count;
  endfunction

  function int unsigned pending();
    return grant_q.size();
  endfunction

  function void note_request(logic [1:0] kind, logic [63:0] addr);
    grant_t      g;
    int unsigned n, idx, k, reserved;
    logic        found;
    logic [63:0] pg;
    g.code = pfa_pkg::ST_OK;
    g.addr = '0;
    n      = live_pages();
    case (kind)
      pfa_pkg::REQ_ALLOC: begin
        g.code = pfa_pkg::ST_OOM;
        found  = 1'b0;
        idx    = (cursor < n) ? cursor : 0;
        for (k = 0; k < n && !found; k++) begin
          if (!used_map[idx]) begin
            used_map[idx] = 1'b1;
            cursor        = idx;
            pg            = 64'(idx);
            g.code        = pfa_pkg::ST_OK;
            g.addr        = base + (pg << pfa_pkg::PAGE_SHIFT);
            found         = 1'b1;
          end else begin
            idx = (idx + 1 >= n) ? 0 : idx + 1;
          end
        end
      end
      pfa_pkg::REQ_FREE: begin
        if (addr < base) begin
          g.code = pfa_pkg::ST_RANGE;
        end else begin
          pg = (addr - base) >> pfa_pkg::PAGE_SHIFT;
          if (pg >= n) g.code = pfa_pkg::ST_RANGE;
          else if (!used_map[pg[15:0]]) g.code = pfa_pkg::ST_NOT_USED;
          else used_map[pg[15:0]] = 1'b0;
        end
      end
      pfa_pkg::REQ_INIT: begin
        reserved = n >> pfa_pkg::PAGE_SHIFT;
        foreach (used_map[i]) used_map[i] = (i < reserved);
        if (reserved > 0) cursor = reserved - 1;
      end
      default: ;
    endcase
    grant_q.push_back(g);
  endfunction

  function void check_result(logic [1:0] code, logic [63:0] addr);
    grant_t g;
    if (grant_q.size() == 0) begin
      if (fail_count < 10)
        $display("unrequested result: status %0d address %h", code, addr);
      fail_count++;
    end else begin
      g = grant_q.pop_front();
      if (code !== g.code || addr !== g.addr) begin
        if (fail_count < 10)
          $display("mismatch: status exp %0d got %0d, address exp %h got %h",
                   g.code, code, g.addr, addr);
        fail_count++;
      end
    end
  endfunction
endclass

module tb_top;
  import pfa_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type;
  logic [63:0] page_address;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [63:0] granted_address;

  frame_map_tracker sb = new();

  int unsigned tx_count = 0;
  int unsigned rx_count = 0;
  logic        tx_calm  = 1'b0;
  logic        rx_calm  = 1'b0;

  page_frame_allocator u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .page_address    (page_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .granted_address (granted_address)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_request(req_type, page_address);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(status, granted_address);
  end

  // result side: random stall per item, with calm stretches
  initial begin
    int unsigned stall;
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && rst === 1'b0));
      rx_count++;
      if (rx_count % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_request(input logic [1:0] kind, input logic [63:0] addr);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= kind;
    page_address <= addr;
    do @(posedge clk); while (in_ready !== 1'b1);
    tx_count++;
    if (tx_count % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
  endtask

  // hold off new requests until every outstanding grant has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_region(input logic [63:0] b, input logic [63:0] c);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REGION_BASE;
    cfg_data  <= b;
    @(posedge clk);
    cfg_index <= CFG_PAGE_COUNT;
    cfg_data  <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_region(b, c);
  endtask

  function automatic logic [63:0] random_page_base();
    return {$urandom, $urandom} & ~64'hFFF;
  endfunction

  task automatic run_random(input logic [63:0] b, input logic [63:0] c,
                            input int unsigned items);
    int unsigned n, sel, idx, cand, k, init_at;
    logic        found;
    logic [1:0]  kind;
    logic [63:0] a, pg;
    program_region(b, c);
    n       = sb.live_pages();
    init_at = $urandom_range(0, items - 1);
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) drain();
      a    = {$urandom, $urandom};
      sel  = $urandom_range(0, 99);
      kind = REQ_FREE;
      if (i == init_at) begin
        kind = REQ_INIT;
      end else if (sel < 45) begin
        kind = REQ_ALLOC;
      end else if (sel < 80 && n > 0) begin
        // free a page that is likely in use, near the cursor or anywhere
        found = 1'b0;
        idx   = sb.cursor % n;
        for (k = 0; k < 16 && !found; k++) begin
          cand = k[0] ? $urandom_range(0, n - 1)
                      : (sb.cursor % n + n - $urandom_range(0, 63) % n) % n;
          if (sb.used_map[cand]) begin
            idx   = cand;
            found = 1'b1;
          end
        end
        pg = 64'(idx);
        a  = b + (pg << PAGE_SHIFT) +
             (($urandom_range(0, 3) == 0) ? {52'd0, a[11:0]} : 64'd0);
      end else if (sel < 84) begin
        kind = REQ_NONE;
      end else begin
        case (sel % 4)
          0: ;
          1: a = b - 64'd1 - {44'd0, a[19:0]};
          2: begin
            pg = 64'(n);
            a  = b + (pg << PAGE_SHIFT) + {48'd0, a[15:0]};
          end
          default: begin
            pg = 64'($urandom_range(0, n));
            a  = b + (pg << PAGE_SHIFT);
          end
        endcase
      end
      send_request(kind, a);
    end
  endtask

  initial begin
    logic [63:0] top_base;
    logic [63:0] mid_base;
    top_base = 64'hFFFF_FFFF_FFFF_E000;
    mid_base = 64'h0000_0000_8000_0000;

    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_REGION_BASE;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    req_type     <= REQ_ALLOC;
    page_address <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty region
    program_region(64'd0, 64'd0);
    send_request(REQ_ALLOC, 64'd0);
    send_request(REQ_FREE, 64'd0);
    send_request(REQ_FREE, '1);
    send_request(REQ_NONE, '1);
    send_request(REQ_INIT, 64'd0);

    // three pages at the top of the address space; the last one wraps to 0
    program_region(top_base, 64'd3);
    repeat (4) send_request(REQ_ALLOC, 64'd0);
    send_request(REQ_FREE, top_base + 64'h1234);
    send_request(REQ_FREE, 64'd0);
    send_request(REQ_FREE, top_base - 64'd1);
    send_request(REQ_FREE, top_base + 64'h1000);
    send_request(REQ_ALLOC, 64'd0);

    // oversized count clamps to the map size; init reserves 16 pages
    program_region(mid_base, '1);
    send_request(REQ_INIT, 64'd0);
    send_request(REQ_ALLOC, 64'd0);
    send_request(REQ_FREE, mid_base + 64'h0FFF_F000);
    send_request(REQ_FREE, mid_base + 64'h1000_0000);
    send_request(REQ_FREE, mid_base);
    send_request(REQ_ALLOC, 64'd0);

    // shrink below the cursor: scan restarts at page 0, then map is full
    program_region(mid_base, 64'd8);
    send_request(REQ_ALLOC, 64'd0);
    send_request(REQ_ALLOC, 64'd0);

    run_random(64'd0, 64'd1, 300);
    run_random(random_page_base(), 64'($urandom_range(2, 24)), 300);
    run_random('1, 64'($urandom_range(8, 40)), 300);
    run_random(random_page_base(), 64'h1_0000, 300);
    run_random(random_page_base(), 64'($urandom_range(4096, 8191)), 300);
    run_random({$urandom, $urandom}, 64'($urandom_range(1, 64)), 300);

    drain();
    repeat (100) @(posedge clk);
    if (sb.pending() != 0) $display("%0d grants never arrived", sb.pending());
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
